@@ rtl/core/nesg_pkg.sv @@
// ----------------------------------------------------------------------------
// Nested set generator package
// Shared constants, channel payload types and the divider interface types.
// ----------------------------------------------------------------------------
package nesg_pkg;

	localparam int MAX_SPAN_DEF  = 64;
	localparam int MAX_DEPTH_DEF = 5;
	localparam int LEVEL_INPUTS  = 5;
	// Width of a span, a level size or a stored position.
	localparam int VAL_W = 7;

	typedef struct packed {
		logic [6:0] span;
		logic [2:0] level_count;
		logic [5:0] count_1;
		logic [5:0] count_2;
		logic [5:0] count_3;
		logic [5:0] count_4;
		logic [5:0] count_5;
		logic [5:0] rotation_1;
		logic [5:0] rotation_2;
		logic [5:0] rotation_3;
		logic [5:0] rotation_4;
		logic [5:0] rotation_5;
	} request_t;

	typedef struct packed {
		logic [5:0] position;
		logic [6:0] interval;
		logic       last;
		logic       param_error;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] dividend;
		logic [VAL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [VAL_W-1:0] quotient;
		logic [VAL_W-1:0] remainder;
	} div_rsp_t;

endpackage

@@ rtl/core/nesg_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module nesg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/nesg_div.sv @@
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle; done pulses once the
// quotient and remainder are ready, and they hold until the next start.
// ----------------------------------------------------------------------------
module nesg_div import nesg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(VAL_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [VAL_W-1:0]  quo_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  div_q;
	logic [VAL_W:0]    rem_sh;
	logic              fits;

	always_comb begin
		rem_sh = {rem_q, quo_q[VAL_W-1]};
		fits   = rem_sh >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VAL_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VAL_W-2:0], fits};
			rem_q <= fits ? VAL_W'(rem_sh - {1'b0, div_q}) : rem_sh[VAL_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

@@ rtl/core/nested_euclidean_set_generator.sv @@
// ----------------------------------------------------------------------------
// Nested evenly spread set generator
// Builds up to five nested levels of evenly spread onsets and streams the
// final onset positions with their intervals.
// ----------------------------------------------------------------------------
// Usage. A request transfer on the request channel carries a span, a depth
// and up to five counts with rotations. The block answers on the result
// channel with one transfer per onset of the final set, in ascending order,
// each carrying its interval to the next onset; the last one wraps through
// the span and has last set. Bad parameters (counts not strictly below the
// previous size, a zero count, a depth out of range or a span above
// MAX_SPAN) give a single result with param_error and last set.
// Timing. One request is worked on at a time. Each level runs two divisions
// in the shared iterative divider (step size, then rotation modulo the
// previous size), streams its elements through the working-set RAMs and
// then swaps them. An error result skips the levels entirely.
// Reset clears all control state; the working-set RAMs are not cleared, since
// every entry is written before it is read within a request.
// A stalled result waits in the output register; emission simply pauses.
// The next request is taken as soon as the last result has been loaded.
// ----------------------------------------------------------------------------
module nested_euclidean_set_generator import nesg_pkg::*; #(
	parameter int MAX_SPAN  = MAX_SPAN_DEF,
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	output logic     request_stall,
	input  request_t request,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	localparam int AW = $clog2(MAX_SPAN);
	localparam logic [3:0] DEPTH_LIM =
		4'((MAX_DEPTH < LEVEL_INPUTS) ? MAX_DEPTH : LEVEL_INPUTS);
	localparam logic [8:0] SPAN_LIM = 9'(MAX_SPAN);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_CHECK = 10'b00_0000_0010,
		S_LVL   = 10'b00_0000_0100,
		S_DQ    = 10'b00_0000_1000,
		S_RM    = 10'b00_0001_0000,
		S_GEN   = 10'b00_0010_0000,
		S_NEXT  = 10'b00_0100_0000,
		S_ERD   = 10'b00_1000_0000,
		S_EMIT  = 10'b01_0000_0000,
		S_ERR   = 10'b10_0000_0000
	} state_t;

	state_t     state_q;
	request_t   req_q;
	logic [2:0] level_q;
	logic [5:0] i_q;
	logic [5:0] k_q;
	logic [6:0] base_q;
	logic [6:0] rmd_q;
	logic [6:0] dq_q;
	logic [6:0] dr_q;
	logic [6:0] r_q;
	logic [5:0] s_find_q;
	logic       wrapped_q;
	logic [5:0] s_prev_q;
	logic       hold_q;
	logic [6:0] first_q;
	logic [6:0] p_q;
	result_t    out_q;
	logic       out_valid_q;

	// Write stage: follows the generating step in the next cycle.
	logic          wr_valid_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [6:0]    wr_val_s1;
	logic          wr_direct_s1;

	logic [6:0] sz  [8];
	logic [6:0] rot [8];
	logic [6:0] prev;
	logic [6:0] cur;
	logic [2:0] depth;
	logic       bad;

	logic [7:0] v_sum;
	logic       wrap;
	logic [6:0] v;
	logic [6:0] src_sum;
	logic [6:0] src_idx;
	logic [7:0] rmd_sum;
	logic       carry;
	logic [6:0] rmd_next;
	logic [6:0] base_next;

	logic [5:0] ek;
	logic [6:0] e_sum;
	logic [6:0] e_idx;
	logic       e_first;
	logic       e_more;
	logic       go;
	logic       emit_read;
	logic       load_out;
	result_t    out_next;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [6:0]    rd_data;
	logic [6:0]    rdata0;
	logic [6:0]    rdata1;
	logic [6:0]    wdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Level sizes: entry zero is the span, entries one to five the counts.
	always_comb begin
		sz[0]  = req_q.span;
		sz[1]  = {1'b0, req_q.count_1};
		sz[2]  = {1'b0, req_q.count_2};
		sz[3]  = {1'b0, req_q.count_3};
		sz[4]  = {1'b0, req_q.count_4};
		sz[5]  = {1'b0, req_q.count_5};
		sz[6]  = '0;
		sz[7]  = '0;
		rot[0] = '0;
		rot[1] = {1'b0, req_q.rotation_1};
		rot[2] = {1'b0, req_q.rotation_2};
		rot[3] = {1'b0, req_q.rotation_3};
		rot[4] = {1'b0, req_q.rotation_4};
		rot[5] = {1'b0, req_q.rotation_5};
		rot[6] = '0;
		rot[7] = '0;
		depth  = req_q.level_count;
		prev   = sz[level_q - 3'd1];
		cur    = sz[level_q];
	end

	always_comb begin
		bad = (depth == '0) || ({1'b0, depth} > DEPTH_LIM) || ({2'b0, req_q.span} > SPAN_LIM);
		for (int j = 1; j <= LEVEL_INPUTS; j++) begin
			if (3'(j) <= depth && (sz[j] == '0 || sz[j-1] <= sz[j])) begin
				bad = 1'b1;
			end
		end
	end

	// Element generation: base tracks floor(i*prev/cur) through the step
	// quotient and remainder, so each element costs one add and compare.
	always_comb begin
		v_sum     = {1'b0, base_q} + {1'b0, r_q};
		wrap      = v_sum >= {1'b0, prev};
		v         = wrap ? 7'(v_sum - {1'b0, prev}) : v_sum[6:0];
		src_sum   = v + {1'b0, s_prev_q};
		src_idx   = (src_sum >= prev) ? (src_sum - prev) : src_sum;
		rmd_sum   = {1'b0, rmd_q} + {1'b0, dr_q};
		carry     = rmd_sum >= {1'b0, cur};
		rmd_next  = carry ? 7'(rmd_sum - {1'b0, cur}) : rmd_sum[6:0];
		base_next = base_q + dq_q + {6'b0, carry};
	end

	// Each set is stored in generation order; the sorted order is that
	// sequence rotated by the index of the first wrapped element.
	always_comb begin
		ek        = (state_q == S_ERD) ? 6'd0 : (k_q + 6'd1);
		e_sum     = {1'b0, ek} + {1'b0, s_prev_q};
		e_idx     = (e_sum >= cur) ? (e_sum - cur) : e_sum;
		e_first   = (k_q == '0);
		e_more    = ({1'b0, k_q} < cur);
		go        = !out_valid_q || !result_stall;
		emit_read = (state_q == S_EMIT) &&
			((e_first && cur != 7'd1) ||
			 (!e_first && e_more && go && ({1'b0, k_q} + 7'd1 < cur)));
		load_out  = go && ((state_q == S_ERR) || (state_q == S_EMIT && !e_first));
	end

	always_comb begin
		out_next = '0;
		if (state_q == S_ERR) begin
			out_next.last        = 1'b1;
			out_next.param_error = 1'b1;
		end else if (e_more) begin
			out_next.position = p_q[5:0];
			out_next.interval = rd_data - p_q;
		end else begin
			out_next.position = p_q[5:0];
			out_next.interval = req_q.span + first_q - p_q;
			out_next.last     = 1'b1;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(e_idx);
		if (state_q == S_GEN && level_q != 3'd1) begin
			rd_en   = 1'b1;
			rd_addr = AW'(src_idx);
		end else if (state_q == S_ERD) begin
			rd_en = 1'b1;
		end else if (emit_read) begin
			rd_en = 1'b1;
		end
	end

	assign rd_data = hold_q ? rdata1 : rdata0;
	assign wdata   = wr_direct_s1 ? wr_val_s1 : rd_data;

	always_comb begin
		div_req = '0;
		if (state_q == S_LVL) begin
			div_req.start    = 1'b1;
			div_req.dividend = prev;
			div_req.divisor  = cur;
		end else if (state_q == S_DQ && div_rsp.done) begin
			div_req.start    = 1'b1;
			div_req.dividend = rot[level_q];
			div_req.divisor  = prev;
		end
	end

	nesg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The two working sets swap roles at every level: one is read, the
	// other receives the composed level.
	nesg_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SPAN)) u_set0 (
		.clk   (clk),
		.we    (wr_valid_s1 && hold_q),
		.waddr (wr_addr_s1),
		.wdata (wdata),
		.re    (rd_en && !hold_q),
		.raddr (rd_addr),
		.rdata (rdata0)
	);

	nesg_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SPAN)) u_set1 (
		.clk   (clk),
		.we    (wr_valid_s1 && !hold_q),
		.waddr (wr_addr_s1),
		.wdata (wdata),
		.re    (rd_en && hold_q),
		.raddr (rd_addr),
		.rdata (rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			level_q     <= '0;
			i_q         <= '0;
			k_q         <= '0;
			wrapped_q   <= 1'b0;
			hold_q      <= 1'b0;
			out_valid_q <= 1'b0;
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= (state_q == S_GEN);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (request_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					level_q <= 3'd1;
					state_q <= bad ? S_ERR : S_LVL;
				end
				S_ERR: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				S_LVL: begin
					state_q <= S_DQ;
				end
				S_DQ: begin
					if (div_rsp.done) begin
						state_q <= S_RM;
					end
				end
				S_RM: begin
					if (div_rsp.done) begin
						i_q       <= '0;
						wrapped_q <= 1'b0;
						state_q   <= S_GEN;
					end
				end
				S_GEN: begin
					if (wrap && !wrapped_q) begin
						wrapped_q <= 1'b1;
					end
					i_q <= i_q + 6'd1;
					if ({1'b0, i_q} + 7'd1 == cur) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					hold_q <= !hold_q;
					if (level_q == depth) begin
						state_q <= S_ERD;
					end else begin
						level_q <= level_q + 3'd1;
						state_q <= S_LVL;
					end
				end
				S_ERD: begin
					k_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (e_first) begin
						k_q <= 6'd1;
					end else if (go) begin
						k_q <= k_q + 6'd1;
						if (!e_more) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && request_valid) begin
			req_q <= request;
		end
		if (state_q == S_DQ && div_rsp.done) begin
			dq_q <= div_rsp.quotient;
			dr_q <= div_rsp.remainder;
		end
		if (state_q == S_RM && div_rsp.done) begin
			r_q      <= div_rsp.remainder;
			base_q   <= '0;
			rmd_q    <= '0;
			s_find_q <= '0;
		end
		if (state_q == S_GEN) begin
			base_q <= base_next;
			rmd_q  <= rmd_next;
			if (wrap && !wrapped_q) begin
				s_find_q <= i_q;
			end
		end
		if (state_q == S_NEXT) begin
			s_prev_q <= wrapped_q ? s_find_q : '0;
		end
		if (state_q == S_EMIT) begin
			if (e_first) begin
				first_q <= rd_data;
				p_q     <= rd_data;
			end else if (go && e_more) begin
				p_q <= rd_data;
			end
		end
		wr_addr_s1   <= AW'(i_q);
		wr_val_s1    <= v;
		wr_direct_s1 <= (level_q == 3'd1);
		if (load_out) begin
			out_q <= out_next;
		end
	end

	assign request_stall = (state_q != S_IDLE);
	assign result_valid  = out_valid_q;
	assign result        = out_q;

	// An error result is a lone result with no interval.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.param_error |-> result.last && result.interval == '0)
		else $error("error result is not a lone zero-interval result");

	// Onsets of a valid set are distinct, so no interval is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.param_error |-> result.interval != '0)
		else $error("zero interval on a regular result");

	// A request transfer always leads into the parameter check.
	assert property (@(posedge clk) disable iff (!arst_n)
		request_valid && !request_stall |=> state_q == S_CHECK)
		else $error("request transfer did not start a check");

	// Emission never runs past the size of the final set.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> {1'b0, k_q} <= cur)
		else $error("emission index beyond final set size");

	// Generation only starts once the divider has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GEN |-> !div_rsp.busy)
		else $error("element generation while divider busy");

endmodule

@@ verif/nesg_onset_checker.sv @@
// ----------------------------------------------------------------------------
// Onset stream checker
// Watches both channels of the nested set generator, predicts the onset
// stream of every accepted request and compares each result transfer with it.
// ----------------------------------------------------------------------------
module nesg_onset_checker import nesg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	input  logic     request_stall,
	input  request_t request,
	input  logic     result_valid,
	input  logic     result_stall,
	input  result_t  result,
	output int       failures,
	output int       outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	result_t expected_onsets[$];

	// Appends one predicted result at the tail of the queue.
	function automatic void queue_result(input result_t r);
		expected_onsets.insert(expected_onsets.size(), r);
	endfunction

	// Works out the whole result stream of one request and queues it.
	function automatic void predict_onsets(input request_t req);
		int unsigned sizes[6];
		int unsigned rots[6];
		int unsigned onsets[64];
		int unsigned level[64];
		int unsigned mapped[64];
		int unsigned depth, prev, cur, v, k, p, gap;
		bit bad;
		result_t r;
		sizes[0] = req.span;
		sizes[1] = req.count_1;
		sizes[2] = req.count_2;
		sizes[3] = req.count_3;
		sizes[4] = req.count_4;
		sizes[5] = req.count_5;
		rots[0] = 0;
		rots[1] = req.rotation_1;
		rots[2] = req.rotation_2;
		rots[3] = req.rotation_3;
		rots[4] = req.rotation_4;
		rots[5] = req.rotation_5;
		depth = req.level_count;
		bad = (depth == 0) || (depth > MAX_DEPTH_DEF) || (depth > LEVEL_INPUTS) ||
			(req.span > MAX_SPAN_DEF);
		for (int j = 1; j <= LEVEL_INPUTS; j++) begin
			if (!bad && j <= depth && (sizes[j] == 0 || sizes[j-1] <= sizes[j]))
				bad = 1'b1;
		end
		if (bad) begin
			r.position    = '0;
			r.interval    = '0;
			r.last        = 1'b1;
			r.param_error = 1'b1;
			queue_result(r);
			return;
		end
		for (int lv = 1; lv <= depth; lv++) begin
			prev = sizes[lv-1];
			cur  = sizes[lv];
			// Evenly spread set, rotated and kept sorted by insertion.
			for (int i = 0; i < cur; i++) begin
				v = ((i * prev) / cur + rots[lv] % prev) % prev;
				k = i;
				while (k > 0 && level[k-1] > v) begin
					level[k] = level[k-1];
					k--;
				end
				level[k] = v;
			end
			// Deeper levels pick members out of the set built so far.
			for (int i = 0; i < cur; i++)
				mapped[i] = (lv == 1) ? level[i] : onsets[level[i] % 64];
			for (int i = 0; i < cur; i++)
				onsets[i] = mapped[i];
		end
		cur = sizes[depth];
		for (int e = 0; e < cur; e++) begin
			p = onsets[e];
			gap = (e + 1 == cur) ? req.span + onsets[0] - p : onsets[e+1] - p;
			r.position    = 6'(p);
			r.interval    = 7'(gap);
			r.last        = (e + 1 == cur);
			r.param_error = 1'b0;
			queue_result(r);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_onsets.size() == 0) begin
					if (failures < REPORT_LIMIT)
						$display("%0t: unexpected result %0d/%0d/%0b/%0b",
							$realtime, result.position, result.interval,
							result.last, result.param_error);
					failures++;
				end else begin
					want = expected_onsets.pop_front();
					if (result.position !== want.position ||
							result.interval !== want.interval ||
							result.last !== want.last ||
							result.param_error !== want.param_error) begin
						if (failures < REPORT_LIMIT)
							$display("%0t: mismatch, want %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
								$realtime, want.position, want.interval, want.last,
								want.param_error, result.position, result.interval,
								result.last, result.param_error);
						failures++;
					end
				end
			end
			if (request_valid && !request_stall)
				predict_onsets(request);
			outstanding <= expected_onsets.size();
		end
	end

endmodule

@@ verif/tb_nested_euclidean_set_generator.sv @@
// ----------------------------------------------------------------------------
// Nested set generator testbench
// Drives directed and random requests through the generator under varying
// sender and receiver idling, while a checker compares every onset result.
// ----------------------------------------------------------------------------
module tb_nested_euclidean_set_generator import nesg_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// The quiet time at the end comfortably outlasts a full five-level request.
	localparam int DRAIN_CYCLES  = 600;
	// Timeout, well beyond the slowest legal run of all requests at full
	// stall pressure.
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int RANDOM_ITEMS  = 320;
	localparam int HOLD_CYCLES   = 500;
	localparam int HOLD_AFTER    = 60;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     request_valid;
	logic     request_stall;
	request_t request;
	logic     result_valid;
	logic     result_stall;
	result_t  result;

	int failures;
	int outstanding;
	int cycle_count = 0;
	int transfers_sent = 0;
	int sender_idle_pct = 18;
	int receiver_idle_pct = 56;
	logic hold_off = 1'b0;

	nested_euclidean_set_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

	nesg_onset_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The watchdog ends a run that hangs, for instance when a result never
	// shows up or the request channel stays stalled forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_nested_euclidean_set_generator: done, errors");
			$finish;
		end
	end

	// The receiver stalls at random at the rate of the current phase, and
	// solidly while a hold-off is in force.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			result_stall <= hold_off || ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// One long hold-off on the result side. The sender keeps offering requests
	// meanwhile, so the generator backs up and has to stall its request input.
	initial begin
		@(posedge clk);
		while (transfers_sent < HOLD_AFTER)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic request_t make_request(input int sp, input int dp,
			input int c1, input int c2, input int c3, input int c4, input int c5,
			input int r1, input int r2, input int r3, input int r4, input int r5);
		request_t req;
		req.span        = 7'(sp);
		req.level_count = 3'(dp);
		req.count_1     = 6'(c1);
		req.count_2     = 6'(c2);
		req.count_3     = 6'(c3);
		req.count_4     = 6'(c4);
		req.count_5     = 6'(c5);
		req.rotation_1  = 6'(r1);
		req.rotation_2  = 6'(r2);
		req.rotation_3  = 6'(r3);
		req.rotation_4  = 6'(r4);
		req.rotation_5  = 6'(r5);
		return req;
	endfunction

	// Most random requests are well formed, with strictly falling counts and
	// random rotations, since only those reach the level building. A share is
	// pure noise over every bit, and another share is a good request with one
	// level broken by a zero or repeated count.
	function automatic request_t random_request();
		request_t req;
		logic [95:0] noise;
		int unsigned pick, depth, broken;
		int unsigned cnt[6];
		pick = $urandom_range(99);
		if (pick < 10) begin
			noise = {$urandom(), $urandom(), $urandom()};
			return request_t'(noise[$bits(request_t)-1:0]);
		end
		depth = $urandom_range(5, 1);
		cnt[0] = (pick < 45) ? $urandom_range(16, depth + 1) : $urandom_range(64, depth + 1);
		for (int j = 1; j <= 5; j++)
			cnt[j] = (j <= depth) ? $urandom_range(cnt[j-1] - 1, depth - j + 1)
				: $urandom_range(63);
		if (pick < 18) begin
			broken = $urandom_range(depth, 1);
			cnt[broken] = $urandom_range(1) ? 0 : cnt[broken-1];
		end
		req = make_request(cnt[0], depth, cnt[1], cnt[2], cnt[3], cnt[4], cnt[5],
			$urandom_range(63), $urandom_range(63), $urandom_range(63),
			$urandom_range(63), $urandom_range(63));
		return req;
	endfunction

	// Offers one request after a random idle gap and holds it until stall is seen
	// low. Valid is only lowered when a gap is actually taken.
	task automatic offer_request(input request_t req);
		while ($urandom_range(99) < sender_idle_pct) begin
			request_valid <= 1'b0;
			@(posedge clk);
		end
		request_valid <= 1'b1;
		request <= req;
		@(posedge clk);
		while (request_stall)
			@(posedge clk);
		transfers_sent++;
	endtask

	initial begin
		arst_n = 1'b0;
		request_valid = 1'b0;
		request = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Good requests at the extremes first.
		// A single onset over the smallest span.
		offer_request(make_request(2, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// A single onset over the largest span gives the largest interval.
		offer_request(make_request(64, 1, 1, 0, 0, 0, 0, 63, 0, 0, 0, 0));
		offer_request(make_request(64, 1, 63, 0, 0, 0, 0, 63, 0, 0, 0, 0));
		// Full depth with the largest counts and rotations.
		offer_request(make_request(64, 5, 63, 62, 61, 60, 59, 63, 63, 63, 63, 63));
		offer_request(make_request(64, 5, 5, 4, 3, 2, 1, 0, 0, 0, 0, 0));
		offer_request(make_request(6, 5, 5, 4, 3, 2, 1, 63, 63, 63, 63, 63));
		// Counts beyond the depth are garbage and must be ignored.
		offer_request(make_request(16, 2, 10, 5, 63, 0, 63, 3, 7, 63, 63, 63));
		// Rotation much larger than the previous level's size.
		offer_request(make_request(8, 1, 3, 0, 0, 0, 0, 63, 0, 0, 0, 0));
		offer_request(make_request(12, 3, 7, 4, 2, 0, 0, 11, 50, 63, 0, 0));
		// Error cases: depth out of range.
		offer_request(make_request(16, 0, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0));
		offer_request(make_request(16, 6, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0));
		offer_request(make_request(16, 7, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0));
		// Span above the supported maximum, and spans too small to hold a set.
		offer_request(make_request(65, 1, 8, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		offer_request(make_request(127, 7, 63, 63, 63, 63, 63, 63, 63, 63, 63, 63));
		offer_request(make_request(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		offer_request(make_request(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Counts not strictly falling, and a zero count within the depth.
		offer_request(make_request(16, 1, 16, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		offer_request(make_request(32, 3, 20, 20, 10, 0, 0, 0, 0, 0, 0, 0));
		offer_request(make_request(32, 3, 20, 10, 0, 0, 0, 0, 0, 0, 0, 0));
		offer_request(make_request(32, 4, 20, 10, 12, 5, 0, 0, 0, 0, 0, 0));

		// Random part in three phases: mostly idle receiver, then mostly idle
		// sender, then both running flat out.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				sender_idle_pct = 56;
				receiver_idle_pct <= 18;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				sender_idle_pct = 0;
				receiver_idle_pct <= 0;
			end
			offer_request(random_request());
		end
		request_valid <= 1'b0;
		@(posedge clk);

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("tb_nested_euclidean_set_generator: done, clean");
		end else begin
			$display("tb_nested_euclidean_set_generator: done, errors");
		end
		$finish;
	end

endmodule
